>>> sv/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and constants shared by the UTF-8 stream validator modules.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam logic [20:0] MAX_CODE = 21'h10FFFF;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_LEAD      = 3'd1,
    ERR_TRUNCATED = 3'd2,
    ERR_CONT      = 3'd3,
    ERR_NULL      = 3'd4,
    ERR_RANGE     = 3'd5,
    ERR_SURROGATE = 3'd6,
    ERR_OVERLONG  = 3'd7
  } err_code_e;

  typedef struct packed {
    logic [1:0]  bytes_rem;
    logic [2:0]  seq_len;
    logic [20:0] partial;
    logic        bad_cont;
    err_code_e   first_err;
  } utf8v_state_t;

  typedef struct packed {
    logic        char_done;
    logic [20:0] code_point;
    err_code_e   error_code;
    logic        string_end;
  } utf8v_result_t;

endpackage

>>> sv/utf8v_decode.sv
// ----------------------------------------------------------------------------
// utf8v_decode
// Combinational decode of one byte against the current string state.
// ----------------------------------------------------------------------------
module utf8v_decode import utf8v_pkg::*; (
  input  logic          nul_ok_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  input  utf8v_state_t  state_i,
  output utf8v_state_t  state_o,
  output utf8v_result_t result_o
);

  function automatic err_code_e check_char(logic [20:0] code, logic [2:0] len,
                                           logic bad, logic allow);
    err_code_e e;
    e = ERR_NONE;
    if (bad) begin
      e = ERR_CONT;
    end else if (len == 3'd1) begin
      e = (code == 21'd0 && !allow) ? ERR_NULL : ERR_NONE;
    end else if (code > MAX_CODE) begin
      e = ERR_RANGE;
    end else if (code[20:11] == 10'h01B) begin
      e = ERR_SURROGATE;
    end else if (len == 3'd2) begin
      if (code >= 21'h80 && code <= 21'h7FF) begin
        e = ERR_NONE;
      end else if (code == 21'd0) begin
        e = allow ? ERR_NONE : ERR_NULL;
      end else begin
        e = ERR_OVERLONG;
      end
    end else if (len == 3'd3) begin
      e = (code >= 21'h800 && code <= 21'hFFFF) ? ERR_NONE : ERR_OVERLONG;
    end else begin
      e = (code >= 21'h10000) ? ERR_NONE : ERR_OVERLONG;
    end
    return e;
  endfunction

  utf8v_state_t nxt;
  err_code_e    err;
  logic         completed;
  logic [20:0]  shifted;
  logic [1:0]   rem_dec;

  assign shifted = {state_i.partial[14:0], data_byte_i[5:0]};
  assign rem_dec = state_i.bytes_rem - 2'd1;

  always_comb begin
    nxt       = state_i;
    err       = ERR_NONE;
    completed = 1'b0;
    if (state_i.bytes_rem == 2'd0) begin
      if (!data_byte_i[7]) begin
        nxt.seq_len = 3'd1;
        nxt.partial = {13'd0, data_byte_i};
        completed   = 1'b1;
        err         = check_char({13'd0, data_byte_i}, 3'd1, 1'b0, nul_ok_i);
      end else if (data_byte_i[7:5] == 3'b110) begin
        nxt.seq_len   = 3'd2;
        nxt.partial   = {16'd0, data_byte_i[4:0]};
        nxt.bytes_rem = 2'd1;
        nxt.bad_cont  = 1'b0;
        err           = last_byte_i ? ERR_TRUNCATED : ERR_NONE;
      end else if (data_byte_i[7:4] == 4'b1110) begin
        nxt.seq_len   = 3'd3;
        nxt.partial   = {17'd0, data_byte_i[3:0]};
        nxt.bytes_rem = 2'd2;
        nxt.bad_cont  = 1'b0;
        err           = last_byte_i ? ERR_TRUNCATED : ERR_NONE;
      end else if (data_byte_i[7:3] == 5'b11110) begin
        nxt.seq_len   = 3'd4;
        nxt.partial   = {18'd0, data_byte_i[2:0]};
        nxt.bytes_rem = 2'd3;
        nxt.bad_cont  = 1'b0;
        err           = last_byte_i ? ERR_TRUNCATED : ERR_NONE;
      end else begin
        err = ERR_LEAD;
      end
    end else begin
      nxt.partial   = shifted;
      nxt.bad_cont  = state_i.bad_cont | (data_byte_i[7:6] != 2'b10);
      nxt.bytes_rem = rem_dec;
      if (rem_dec == 2'd0) begin
        completed    = 1'b1;
        err          = check_char(shifted, state_i.seq_len, nxt.bad_cont, nul_ok_i);
        nxt.bad_cont = 1'b0;
      end else if (last_byte_i) begin
        err = ERR_TRUNCATED;
      end
    end

    if (state_i.first_err == ERR_NONE && err != ERR_NONE) begin
      nxt.first_err = err;
    end

    result_o.char_done  = completed && err == ERR_NONE && nxt.first_err == ERR_NONE;
    result_o.code_point = result_o.char_done ? nxt.partial : 21'd0;
    result_o.error_code = nxt.first_err;
    result_o.string_end = last_byte_i;

    if (last_byte_i) begin
      state_o = '{bytes_rem: 2'd0, seq_len: 3'd0, partial: 21'd0,
                  bad_cont: 1'b0, first_err: ERR_NONE};
    end else begin
      state_o = nxt;
    end
  end

endmodule

>>> sv/utf8v_out_buf.sv
// ----------------------------------------------------------------------------
// utf8v_out_buf
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module utf8v_out_buf import utf8v_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utf8v_result_t push_data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_ready_i,
  output utf8v_result_t data_o
);

  logic          main_valid_q, main_valid_d;
  logic          skid_valid_q, skid_valid_d;
  utf8v_result_t main_q, main_d;
  utf8v_result_t skid_q, skid_d;
  logic          pop;

  assign pop     = main_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
      main_q       <= '0;
      skid_q       <= '0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
      main_q       <= main_d;
      skid_q       <= skid_d;
    end
  end

endmodule

>>> sv/utf8_stream_validator_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_top
// Checks a byte stream against the UTF-8 rules and reports one result per
// byte with the decoded code point and the sticky first error of the string.
//
// The input channel moves one word per byte: data_byte_i with last_byte_i on
// the final byte of a string. The output channel moves one result word per
// input word, in order. The single configuration register nul_ok, which
// permits zero bytes and the two-byte NUL, must be written through cfg_we_i
// and cfg_wdata_i while the block is idle; the block does not enforce this.
// A result is registered when its byte is accepted. One byte can be accepted
// in every cycle while in_ready_o is high, since the decode of a byte is a
// single pass of logic between the string state and the output register.
// A skid register behind the output register lets the block take one more
// byte while a result waits; in_ready_o drops only when both hold results,
// and rises again as soon as the receiver takes one.
// Reset clears the string state, nul_ok and both result registers.
// The result for the last byte of a string carries the final verdict, and
// the string state clears itself for the next string.
// ----------------------------------------------------------------------------
module utf8_stream_validator_top import utf8v_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        char_done_o,
  output logic [20:0] code_point_o,
  output logic [2:0]  error_code_o,
  output logic        string_end_o
);

  logic          nul_ok_q;
  utf8v_state_t  state_q, state_d;
  utf8v_result_t result, out_data;
  logic          accept;

  assign accept = in_valid_i && in_ready_o;

  utf8v_decode u_decode (
    .nul_ok_i    (nul_ok_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  utf8v_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .data_o      (out_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nul_ok_q <= 1'b0;
      state_q  <= '{bytes_rem: 2'd0, seq_len: 3'd0, partial: 21'd0,
                    bad_cont: 1'b0, first_err: ERR_NONE};
    end else begin
      if (cfg_we_i) begin
        nul_ok_q <= cfg_wdata_i;
      end
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  assign char_done_o  = out_data.char_done;
  assign code_point_o = out_data.code_point;
  assign error_code_o = out_data.error_code;
  assign string_end_o = out_data.string_end;

endmodule

>>> sv/utf8v_checker.sv
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level checks of the UTF-8 stream validator, bound to its top level.
// ----------------------------------------------------------------------------
module utf8v_checker import utf8v_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        char_done_o,
  input logic [20:0] code_point_o,
  input logic [2:0]  error_code_o,
  input logic        string_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o) &&
      $stable(error_code_o) && $stable(char_done_o) && $stable(string_end_o))
    else $error("Result word changed while stalled.");

  a_full_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("Input stalled with no result waiting.");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_done_o |-> error_code_o == ERR_NONE && code_point_o <= MAX_CODE)
    else $error("Completed character reported with an error or out of range.");

  a_idle_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_done_o |-> code_point_o == 21'd0)
    else $error("Code point nonzero without a completed character.");

endmodule

bind utf8_stream_validator_top utf8v_checker u_utf8v_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .char_done_o  (char_done_o),
  .code_point_o (code_point_o),
  .error_code_o (error_code_o),
  .string_end_o (string_end_o)
);
